// ===== rtl/core/vdna_pkg.sv =====
// vdna_pkg: shared types and helpers for the vertex dedup / normal accumulate block
// payload structs, stored entry, chain token, saturating add; no dependencies
`default_nettype none

package vdna_pkg;

  localparam int unsigned VDNA_MAX_VERTICES = 1024;
  localparam int unsigned VDNA_N_CELLS      = 32;
  localparam int unsigned VDNA_OUT_IDX_W    = 11;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
  } vdna_in_t;

  typedef struct packed {
    logic [VDNA_OUT_IDX_W-1:0] vertex_index;
    logic                      was_found;
    logic                      table_full;
    logic signed [31:0]        sum_x;
    logic signed [31:0]        sum_y;
    logic signed [31:0]        sum_z;
  } vdna_out_t;

  // one stored vertex: position key and running normal sum
  typedef struct packed {
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
  } vdna_entry_t;

  // token handed from cell to cell during a search
  typedef struct packed {
    logic               vld;
    logic               last;
    logic               hit;
    logic signed [31:0] sum_x;
    logic signed [31:0] sum_y;
    logic signed [31:0] sum_z;
  } vdna_tok_t;

  function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return s[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vdna_stream_if.sv =====
// vdna_in_if / vdna_out_if: valid/ready channels for vertex requests and results
// depends on vdna_pkg for the payload structs
`default_nettype none

interface vdna_in_if;
  logic              valid;
  logic              ready;
  vdna_pkg::vdna_in_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface vdna_out_if;
  logic               valid;
  logic               ready;
  vdna_pkg::vdna_out_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vdna_cell.sv =====
// vdna_cell: one bank of the vertex table plus its compare / accumulate stage
// depends on vdna_pkg; instantiated in a row by vertex_dedup_normal_accumulate
`default_nettype none

module vdna_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned DEPTH    = 1,
  parameter int unsigned ADDR_W   = 1,
  parameter int unsigned IDX_W    = 11
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire vdna_pkg::vdna_in_t    qry_i,
  input  wire logic [IDX_W-1:0]      count_i,
  input  wire vdna_pkg::vdna_tok_t   tok_i,
  input  wire logic [ADDR_W-1:0]     addr_i,
  input  wire logic [IDX_W-1:0]      idx_i,
  output vdna_pkg::vdna_tok_t        tok_o,
  output logic [ADDR_W-1:0]          addr_o,
  output logic [IDX_W-1:0]           idx_o,
  input  wire logic                  wr_en_i,
  input  wire logic [ADDR_W-1:0]     wr_addr_i,
  input  wire vdna_pkg::vdna_entry_t wr_entry_i
);
  import vdna_pkg::*;

  localparam int unsigned BASE = CELL_IDX * DEPTH;

  vdna_entry_t       mem_q [DEPTH];
  vdna_entry_t       rd_q;
  vdna_tok_t         tok_q;
  logic [ADDR_W-1:0] addr_q;
  logic [IDX_W-1:0]  idx_q;

  logic [IDX_W:0]     gidx;
  logic               live;
  logic               match;
  logic signed [31:0] sx, sy, sz;
  vdna_entry_t        wb;

  always_comb begin
    gidx  = (IDX_W+1)'(BASE) + (IDX_W+1)'(addr_q);
    live  = gidx < {1'b0, count_i};
    match = tok_q.vld && live &&
            (rd_q.key_x == qry_i.pos_x) &&
            (rd_q.key_y == qry_i.pos_y) &&
            (rd_q.key_z == qry_i.pos_z);
    sx = sat_add(rd_q.acc_x, qry_i.nrm_x);
    sy = sat_add(rd_q.acc_y, qry_i.nrm_y);
    sz = sat_add(rd_q.acc_z, qry_i.nrm_z);
    wb = '{key_x: rd_q.key_x, key_y: rd_q.key_y, key_z: rd_q.key_z,
           acc_x: sx, acc_y: sy, acc_z: sz};
    tok_o = tok_q;
    if (match) begin
      tok_o.hit   = 1'b1;
      tok_o.sum_x = sx;
      tok_o.sum_y = sy;
      tok_o.sum_z = sz;
    end
    addr_o = addr_q;
    idx_o  = match ? gidx[IDX_W-1:0] : idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_i;
    end
  end

  // bank storage: hit write-back and append never land in the same cycle
  always_ff @(posedge clk_i) begin
    rd_q   <= mem_q[addr_i];
    addr_q <= addr_i;
    idx_q  <= idx_i;
    if (match) begin
      mem_q[addr_q] <= wb;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vertex_dedup_normal_accumulate.sv =====
// vertex_dedup_normal_accumulate: welds vertices by exact position, sums normals
// depends on vdna_pkg, vdna_in_if / vdna_out_if and vdna_cell
//
//   channel  dir  modport  payload
//   vtx_i    in   sink     pos_x/y/z, nrm_x/y/z (signed Q16.16)
//   res_o    out  source   vertex_index, was_found, table_full, sum_x/y/z
//
// one request at a time: the address counter sweeps the bank depth
// DEPTH = ceil(MAX_VERTICES / NC), then the last search token walks through
// all NC cells before the result is registered; a stalled result holds in
// the output register while the next request is already taken and searched
// reset clears control only; table contents are undefined until appended
`default_nettype none

module vertex_dedup_normal_accumulate #(
  parameter int unsigned MAX_VERTICES = vdna_pkg::VDNA_MAX_VERTICES,
  parameter int unsigned N_CELLS      = vdna_pkg::VDNA_N_CELLS
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  vdna_in_if.sink    vtx_i,
  vdna_out_if.source res_o
);
  import vdna_pkg::*;

  // never more cells than table entries
  localparam int unsigned NC     = (N_CELLS < MAX_VERTICES) ? N_CELLS : MAX_VERTICES;
  localparam int unsigned DEPTH  = (MAX_VERTICES + NC - 1) / NC;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CELL_W = (NC > 1) ? $clog2(NC) : 1;
  localparam int unsigned IDX_W  = $clog2(MAX_VERTICES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e            state_q;
  vdna_in_t          qry_q;
  logic [ADDR_W-1:0] addr_q;       // search address issued into the first cell
  logic [IDX_W-1:0]  count_q;      // number of stored vertices
  logic [CELL_W-1:0] wbank_q;      // bank and row of the next free entry
  logic [ADDR_W-1:0] waddr_q;
  logic              hit_q;
  logic [IDX_W-1:0]  hit_idx_q;
  logic signed [31:0] hit_sx_q, hit_sy_q, hit_sz_q;
  logic              res_vld_q;
  vdna_out_t         res_q;

  // chain of tokens between cells, element 0 fed from here
  vdna_tok_t         tok_w  [NC+1];
  logic [ADDR_W-1:0] addr_w [NC+1];
  logic [IDX_W-1:0]  idx_w  [NC+1];

  logic        out_free;
  logic        full;
  logic        app_en;
  vdna_entry_t app_entry;
  logic [IDX_W+VDNA_OUT_IDX_W-1:0] idx_ext;
  logic [IDX_W+VDNA_OUT_IDX_W-1:0] full_ext;

  always_comb begin
    out_free  = !res_vld_q || res_o.ready;
    full      = count_q == IDX_W'(MAX_VERTICES);
    // append only once the whole table has been searched without a hit
    app_en    = (state_q == ST_FINISH) && out_free && !hit_q && !full;
    app_entry = '{key_x: qry_q.pos_x, key_y: qry_q.pos_y, key_z: qry_q.pos_z,
                  acc_x: qry_q.nrm_x, acc_y: qry_q.nrm_y, acc_z: qry_q.nrm_z};
    // index field is 11 bits: extend or truncate the internal index
    idx_ext   = {{VDNA_OUT_IDX_W{1'b0}}, (hit_q ? hit_idx_q : count_q)};
    full_ext  = {{VDNA_OUT_IDX_W{1'b0}}, IDX_W'(MAX_VERTICES)};
  end

  assign tok_w[0]  = '{vld: state_q == ST_SCAN, last: addr_q == ADDR_W'(DEPTH - 1),
                       hit: 1'b0, sum_x: '0, sum_y: '0, sum_z: '0};
  assign addr_w[0] = addr_q;
  assign idx_w[0]  = '0;

  assign vtx_i.ready = state_q == ST_IDLE;
  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    vdna_cell #(
      .CELL_IDX(k),
      .DEPTH   (DEPTH),
      .ADDR_W  (ADDR_W),
      .IDX_W   (IDX_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .qry_i     (qry_q),
      .count_i   (count_q),
      .tok_i     (tok_w[k]),
      .addr_i    (addr_w[k]),
      .idx_i     (idx_w[k]),
      .tok_o     (tok_w[k+1]),
      .addr_o    (addr_w[k+1]),
      .idx_o     (idx_w[k+1]),
      .wr_en_i   (app_en && (wbank_q == CELL_W'(k))),
      .wr_addr_i (waddr_q),
      .wr_entry_i(app_entry)
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      addr_q    <= '0;
      count_q   <= '0;
      wbank_q   <= '0;
      waddr_q   <= '0;
      hit_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      // a result leaving while a new one is loaded is handled in ST_FINISH
      if (res_vld_q && res_o.ready && (state_q != ST_FINISH)) begin
        res_vld_q <= 1'b0;
      end

      // at most one stored position can match, so one capture per search
      if (tok_w[NC].vld && tok_w[NC].hit) begin
        hit_q     <= 1'b1;
        hit_idx_q <= idx_w[NC];
        hit_sx_q  <= tok_w[NC].sum_x;
        hit_sy_q  <= tok_w[NC].sum_y;
        hit_sz_q  <= tok_w[NC].sum_z;
      end

      case (state_q)
        ST_IDLE: begin
          if (vtx_i.valid) begin
            qry_q   <= vtx_i.data;
            addr_q  <= '0;
            hit_q   <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (addr_q == ADDR_W'(DEPTH - 1)) begin
            state_q <= ST_DRAIN;
          end else begin
            addr_q <= addr_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          // last token leaving the far end of the chain
          if (tok_w[NC].vld && tok_w[NC].last) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            res_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
            if (hit_q) begin
              res_q <= '{vertex_index: idx_ext[VDNA_OUT_IDX_W-1:0], was_found: 1'b1,
                         table_full: 1'b0, sum_x: hit_sx_q, sum_y: hit_sy_q,
                         sum_z: hit_sz_q};
            end else if (full) begin
              res_q <= '{vertex_index: full_ext[VDNA_OUT_IDX_W-1:0], was_found: 1'b0,
                         table_full: 1'b1, sum_x: '0, sum_y: '0, sum_z: '0};
            end else begin
              res_q <= '{vertex_index: idx_ext[VDNA_OUT_IDX_W-1:0], was_found: 1'b0,
                         table_full: 1'b0, sum_x: qry_q.nrm_x, sum_y: qry_q.nrm_y,
                         sum_z: qry_q.nrm_z};
              count_q <= count_q + 1'b1;
              if (waddr_q == ADDR_W'(DEPTH - 1)) begin
                waddr_q <= '0;
                wbank_q <= wbank_q + 1'b1;
              end else begin
                waddr_q <= waddr_q + 1'b1;
              end
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
